### rtl/i2c_mbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, bus constants and the line drive pattern of each bus phase.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

    typedef enum logic [2:0] {
        CMD_IDLE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_WRITE   = 3'd3,
        CMD_READ    = 3'd4,
        CMD_RECOVER = 3'd5
    } cmd_t;

    localparam int unsigned TICK_W = 16;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd5;

    // Slot numbering inside a command.
    localparam logic [3:0] DATA_LAST_SLOT   = 4'd8;
    localparam logic [3:0] RECOVER_CLOCKS   = 4'd9;
    localparam logic [3:0] RECOVER_START2   = RECOVER_CLOCKS + 4'd1;
    localparam logic [3:0] RECOVER_STOP     = RECOVER_CLOCKS + 4'd2;

    localparam logic [1:0] PHASE_CLK_HIGH   = 2'd1;
    localparam logic [1:0] PHASE_LAST_START = 2'd3;
    localparam logic [1:0] PHASE_LAST_SLOT  = 2'd2;

    function automatic logic start_slot(input cmd_t cmd, input logic [3:0] bi);
        return (cmd == CMD_START) ||
               ((cmd == CMD_RECOVER) && ((bi == 4'd0) || (bi == RECOVER_START2)));
    endfunction

    function automatic logic stop_slot(input cmd_t cmd, input logic [3:0] bi);
        return (cmd == CMD_STOP) || ((cmd == CMD_RECOVER) && (bi == RECOVER_STOP));
    endfunction

    function automatic logic [3:0] last_slot(input cmd_t cmd);
        logic [3:0] r;
        unique case (cmd)
            CMD_WRITE, CMD_READ: r = DATA_LAST_SLOT;
            CMD_RECOVER:         r = RECOVER_STOP;
            default:             r = 4'd0;
        endcase
        return r;
    endfunction

    // Returns {scl, sda} for the given phase of the current slot.
    function automatic logic [1:0] drive(input cmd_t cmd, input logic [1:0] ph,
                                         input logic [3:0] bi, input logic [7:0] sh);
        logic [1:0] r;
        if (start_slot(cmd, bi)) begin
            unique case (ph)
                2'd0:    r = 2'b01;
                2'd1:    r = 2'b11;
                2'd2:    r = 2'b10;
                default: r = 2'b00;
            endcase
        end else if (stop_slot(cmd, bi)) begin
            unique case (ph)
                2'd0:    r = 2'b00;
                2'd1:    r = 2'b10;
                default: r = 2'b11;
            endcase
        end else begin
            r[1] = (ph == PHASE_CLK_HIGH);
            r[0] = ((cmd == CMD_WRITE) && (bi < DATA_LAST_SLOT)) ? sh[7] : 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/i2c_master_byte_engine_top.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C bus sequencer stepped by one tick request per stream item.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel is one bus tick. It carries a command
// code, the byte to write and the sampled SDA level. A command is taken only
// while the engine is idle; during a command the code and byte are ignored.
// Every tick request produces exactly one result request on m_axis with the
// SCL/SDA drive of that tick, busy and done flags, the last read byte and the
// last acknowledge level. Each bus phase lasts phase_ticks ticks (zero acts
// as one), written through cfg_wr_en/cfg_wr_data while the engine is idle:
// the user must keep to this, the block itself does not enforce it. A result
// appears in the cycle after its tick is taken. One tick is taken per cycle
// while results are taken; the whole tick update is one pass of logic from the
// state registers into the result register. When the receiver stalls, the
// result register holds its request and a new tick is taken only in a cycle
// in which that result is being taken. Reset leaves both lines released, the
// engine idle, ack level 1, read byte 0 and phase_ticks at 5.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [i2c_mbe_pkg::TICK_W-1:0]   cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: func[2:0], tx_byte[10:3], sda_in[11], zero[15:12]
    input  logic [15:0]                      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: scl_release[0], sda_release[1], busy_res[2], done_res[3],
    //        rx_byte[11:4], ack_level[12], zero[15:13]
    output logic [15:0]                      m_axis_tdata
);
    import i2c_mbe_pkg::*;

    logic [TICK_W-1:0] phase_ticks_reg;
    cmd_t              cmd_reg,      cmd_next;
    logic [1:0]        phase_reg,    phase_next;
    logic [3:0]        bit_reg,      bit_next;
    logic [TICK_W-1:0] tick_reg,     tick_next;
    logic [7:0]        shift_reg,    shift_next;
    logic              ack_reg,      ack_next;
    logic              scl_reg,      scl_next;
    logic              sda_reg,      sda_next;
    logic [7:0]        rx_reg,       rx_next;
    logic              done_next;
    logic              out_scl, out_sda;
    logic              ovalid_reg;
    logic [12:0]       odata_reg;

    logic [2:0]        in_func;
    logic [7:0]        in_byte;
    logic              in_sda;
    logic              in_acc;
    logic [TICK_W-1:0] limit;
    logic [1:0]        drv_acc, drv_new;

    assign in_func = s_axis_tdata[2:0];
    assign in_byte = s_axis_tdata[10:3];
    assign in_sda  = s_axis_tdata[11];

    assign s_axis_tready = !ovalid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign limit         = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;

    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rx_next    = rx_reg;
        done_next  = 1'b0;
        drv_acc    = 2'b11;
        drv_new    = 2'b11;

        // Command accept: the first phase is driven on this same tick.
        if ((cmd_reg == CMD_IDLE) && (in_func >= CMD_START) && (in_func <= CMD_RECOVER)) begin
            cmd_next   = cmd_t'(in_func);
            phase_next = 2'd0;
            bit_next   = 4'd0;
            tick_next  = '0;
            if (cmd_next == CMD_WRITE) begin
                shift_next = in_byte;
            end else if (cmd_next == CMD_READ) begin
                shift_next = 8'd0;
            end
            drv_acc  = drive(cmd_next, phase_next, bit_next, shift_next);
            scl_next = drv_acc[1];
            sda_next = drv_acc[0];
        end

        out_scl = scl_next;
        out_sda = sda_next;

        if (cmd_next != CMD_IDLE) begin
            tick_next = tick_next + TICK_W'(1);
            if (tick_next >= limit) begin
                tick_next = '0;
                // SDA is sampled at the end of the SCL-high phase of a data slot.
                if ((phase_next == PHASE_CLK_HIGH) && !start_slot(cmd_next, bit_next) &&
                    !stop_slot(cmd_next, bit_next)) begin
                    if ((cmd_next == CMD_WRITE) && (bit_next == DATA_LAST_SLOT)) begin
                        ack_next = in_sda;
                    end else if ((cmd_next == CMD_READ) && (bit_next < DATA_LAST_SLOT)) begin
                        shift_next = {shift_next[6:0], in_sda};
                    end
                end
                if (phase_next < (start_slot(cmd_next, bit_next) ? PHASE_LAST_START
                                                                 : PHASE_LAST_SLOT)) begin
                    phase_next = phase_next + 2'd1;
                end else begin
                    phase_next = 2'd0;
                    if ((cmd_next == CMD_WRITE) && (bit_next < DATA_LAST_SLOT)) begin
                        shift_next = {shift_next[6:0], 1'b0};
                    end
                    if (bit_next < last_slot(cmd_next)) begin
                        bit_next = bit_next + 4'd1;
                    end else begin
                        if (cmd_next == CMD_READ) begin
                            rx_next = shift_next;
                        end
                        cmd_next  = CMD_IDLE;
                        bit_next  = 4'd0;
                        done_next = 1'b1;
                    end
                end
                if (cmd_next != CMD_IDLE) begin
                    drv_new  = drive(cmd_next, phase_next, bit_next, shift_next);
                    scl_next = drv_new[1];
                    sda_next = drv_new[0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            cmd_reg         <= CMD_IDLE;
            phase_reg       <= 2'd0;
            bit_reg         <= 4'd0;
            tick_reg        <= '0;
            shift_reg       <= 8'd0;
            ack_reg         <= 1'b1;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            rx_reg          <= 8'd0;
            ovalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                phase_ticks_reg <= cfg_wr_data;
            end
            if (in_acc) begin
                cmd_reg    <= cmd_next;
                phase_reg  <= phase_next;
                bit_reg    <= bit_next;
                tick_reg   <= tick_next;
                shift_reg  <= shift_next;
                ack_reg    <= ack_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                rx_reg     <= rx_next;
                ovalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            odata_reg <= {ack_next, rx_next, done_next, (cmd_next != CMD_IDLE),
                          out_sda, out_scl};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {3'b000, odata_reg};

    // A tick request always yields a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> m_axis_tvalid)
        else $error("result missing after accepted tick");

    // A completion tick never reports busy.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> !m_axis_tdata[2])
        else $error("done and busy reported together");

    // Idle engine sits at the first phase of slot zero.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg == CMD_IDLE) |-> ((phase_reg == 2'd0) && (bit_reg == 4'd0)))
        else $error("idle with stale sequencer position");

    // The fourth phase exists only in start slots.
    a_phase3_start: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_LAST_START) |-> start_slot(cmd_reg, bit_reg))
        else $error("fourth phase outside a start slot");

    // The phase tick counter stays below the phase length while busy.
    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg != CMD_IDLE) |-> (tick_reg < limit))
        else $error("phase tick counter overran");

endmodule
